FILE: rtl/tfn_pkg.sv
// tfn_pkg: shared types, widths and constants for the triangle face normal pipeline
// no dependencies
`timescale 1ns / 1ps
package tfn_pkg;
  localparam int CW = 24;   // coordinate width
  localparam int EW = 25;   // edge width
  localparam int PW = 50;   // product / cross width
  localparam int MW = 30;   // normalised magnitude width
  localparam int SW = 62;   // sum of squares width
  localparam int LW = 31;   // root width
  localparam int QW = 15;   // quotient magnitude width
  localparam int NW = 16;   // output width
  localparam int KW = 5;    // shift amount width
  localparam logic [QW-1:0] NORM_ONE = 15'd16384;

  // per item side band that travels with the data
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
    logic       last;
  } tfn_side_t;
endpackage

FILE: rtl/triangle_face_normal.sv
// triangle face normal: registered pipeline from start to out_valid
// throughput one triangle per cycle, busy is always low
// the square root (31 stages) and the divider (16 stages) set the depth
// rst_n synchronous active low clears all valid bits; the receiver cannot stall
// depends on tfn_pkg, tfn_sqrt, tfn_div
`timescale 1ns / 1ps
module triangle_face_normal import tfn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_v0_x,
  input  logic signed [CW-1:0] in_v0_y,
  input  logic signed [CW-1:0] in_v0_z,
  input  logic signed [CW-1:0] in_v1_x,
  input  logic signed [CW-1:0] in_v1_y,
  input  logic signed [CW-1:0] in_v1_z,
  input  logic signed [CW-1:0] in_v2_x,
  input  logic signed [CW-1:0] in_v2_y,
  input  logic signed [CW-1:0] in_v2_z,
  input  logic                 in_last_triangle,
  output logic                 out_valid,
  output logic signed [NW-1:0] out_normal_x,
  output logic signed [NW-1:0] out_normal_y,
  output logic signed [NW-1:0] out_normal_z,
  output logic                 out_degenerate,
  output logic                 out_last_out
);
  assign busy = 1'b0;

  // stage 1: edges
  logic              s1_vld_r;
  logic signed [EW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic              s1_last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
    ax_r <= EW'(in_v0_x) - EW'(in_v1_x);
    ay_r <= EW'(in_v0_y) - EW'(in_v1_y);
    az_r <= EW'(in_v0_z) - EW'(in_v1_z);
    bx_r <= EW'(in_v0_x) - EW'(in_v2_x);
    by_r <= EW'(in_v0_y) - EW'(in_v2_y);
    bz_r <= EW'(in_v0_z) - EW'(in_v2_z);
    s1_last_r <= in_last_triangle;
  end

  // stage 2: six products
  logic              s2_vld_r, s2_last_r;
  logic signed [PW-1:0] p_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    p_r[0] <= ay_r * bz_r;
    p_r[1] <= az_r * by_r;
    p_r[2] <= az_r * bx_r;
    p_r[3] <= ax_r * bz_r;
    p_r[4] <= ax_r * by_r;
    p_r[5] <= ay_r * bx_r;
    s2_last_r <= s1_last_r;
  end

  // stage 3: cross product components
  logic              s3_vld_r, s3_last_r;
  logic signed [PW-1:0] c_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    c_r[0] <= p_r[0] - p_r[1];
    c_r[1] <= p_r[2] - p_r[3];
    c_r[2] <= p_r[4] - p_r[5];
    s3_last_r <= s2_last_r;
  end

  // stage 4: magnitudes, signs and the common shift
  logic              s4_vld_r;
  tfn_side_t         s4_side_r;
  logic [PW-1:0]     m4_r [3];
  logic [KW-1:0]     k4_r;
  logic [PW-1:0]     m_nxt [3];
  logic [PW-1:0]     or_all;
  logic [KW-1:0]     k_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) m_nxt[i] = c_r[i][PW-1] ? PW'(-c_r[i]) : PW'(c_r[i]);
    or_all = m_nxt[0] | m_nxt[1] | m_nxt[2];
    k_nxt = '0;
    for (int b = MW; b < PW; b++) if (or_all[b]) k_nxt = KW'(b - MW + 1);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
    for (int i = 0; i < 3; i++) m4_r[i] <= m_nxt[i];
    k4_r <= k_nxt;
    s4_side_r.neg   <= {c_r[2][PW-1], c_r[1][PW-1], c_r[0][PW-1]};
    s4_side_r.degen <= (or_all == '0);
    s4_side_r.last  <= s3_last_r;
  end

  // stage 5: apply shift
  logic              s5_vld_r;
  tfn_side_t         s5_side_r;
  logic [MW-1:0]     m5_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
    for (int i = 0; i < 3; i++) m5_r[i] <= MW'(m4_r[i] >> k4_r);
    s5_side_r <= s4_side_r;
  end

  // stage 6: squares
  logic              s6_vld_r;
  tfn_side_t         s6_side_r;
  logic [SW-1:0]     sq_r [3];
  logic [MW-1:0]     m6_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= SW'(m5_r[i] * m5_r[i]);
      m6_r[i] <= m5_r[i];
    end
    s6_side_r <= s5_side_r;
  end

  // stage 7: sum of squares
  logic              s7_vld_r;
  tfn_side_t         s7_side_r;
  logic [SW-1:0]     s7_r;
  logic [3*MW-1:0]   m7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else        s7_vld_r <= s6_vld_r;
    s7_r <= sq_r[0] + sq_r[1] + sq_r[2];
    m7_r <= {m6_r[2], m6_r[1], m6_r[0]};
    s7_side_r <= s6_side_r;
  end

  // square root and division pipelines
  logic              sq_vld;
  logic [LW-1:0]     sq_root;
  logic [3*MW-1:0]   sq_m;
  tfn_side_t         sq_side;
  tfn_sqrt u_sqrt (
    .clk, .rst_n,
    .in_vld(s7_vld_r), .in_s(s7_r), .in_m(m7_r), .in_side(s7_side_r),
    .out_vld(sq_vld), .out_root(sq_root), .out_m(sq_m), .out_side(sq_side)
  );

  logic              dv_vld;
  logic [3*QW-1:0]   dv_q;
  tfn_side_t         dv_side;
  logic [LW-1:0]     root_safe;
  assign root_safe = (sq_root == '0) ? LW'(1) : sq_root;
  tfn_div u_div (
    .clk, .rst_n,
    .in_vld(sq_vld), .in_root(root_safe), .in_m(sq_m), .in_side(sq_side),
    .out_vld(dv_vld), .out_q(dv_q), .out_side(dv_side)
  );

  // output register: sign and degenerate forcing
  logic              out_vld_r;
  logic [NW-1:0]     nrm_r [3];
  logic              degen_r, last_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld;
    for (int i = 0; i < 3; i++) begin
      if (dv_side.degen)       nrm_r[i] <= '0;
      else if (dv_side.neg[i]) nrm_r[i] <= NW'(-{1'b0, dv_q[i*QW +: QW]});
      else                     nrm_r[i] <= {1'b0, dv_q[i*QW +: QW]};
    end
    degen_r <= dv_side.degen;
    last_r  <= dv_side.last;
  end

  assign out_valid      = out_vld_r;
  assign out_normal_x   = nrm_r[0];
  assign out_normal_y   = nrm_r[1];
  assign out_normal_z   = nrm_r[2];
  assign out_degenerate = degen_r;
  assign out_last_out   = last_r;
endmodule

FILE: rtl/tfn_sqrt.sv
// tfn_sqrt: pipelined restoring square root, one result bit per stage
// depends on tfn_pkg
`timescale 1ns / 1ps
module tfn_sqrt import tfn_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [SW-1:0]       in_s,
  input  logic [3*MW-1:0]     in_m,
  input  tfn_side_t           in_side,
  output logic                out_vld,
  output logic [LW-1:0]       out_root,
  output logic [3*MW-1:0]     out_m,
  output tfn_side_t           out_side
);
  // stage registers, one per root bit
  logic [LW:0]      vld_r;
  logic [SW-1:0]    rem_r  [LW+1];
  logic [LW-1:0]    root_r [LW+1];
  logic [3*MW-1:0]  m_r    [LW+1];
  tfn_side_t        side_r [LW+1];

  always_comb begin
    rem_r[0]  = in_s;
    root_r[0] = '0;
    m_r[0]    = in_m;
    side_r[0] = in_side;
    vld_r[0]  = in_vld;
  end

  for (genvar g = 0; g < LW; g++) begin : g_bit
    localparam int B = LW - 1 - g;
    logic [SW+1:0] trial;
    logic [SW+1:0] rem_w;
    logic [SW-1:0] rem_nxt;
    logic [LW-1:0] root_nxt;
    // trial = (root << (B + 1)) | (1 << 2*B), root holds the bits above B
    always_comb begin
      trial = ({{(SW+2-LW){1'b0}}, root_r[g]} << (B + 1))
            | ({{(SW+1){1'b0}}, 1'b1} << (2 * B));
      rem_w = {2'b00, rem_r[g]};
      if (rem_w >= trial) begin
        rem_nxt  = SW'(rem_w - trial);
        root_nxt = root_r[g] | (LW'(1) << B);
      end else begin
        rem_nxt  = rem_r[g];
        root_nxt = root_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      rem_r[g+1]  <= rem_nxt;
      root_r[g+1] <= root_nxt;
      m_r[g+1]    <= m_r[g];
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_vld  = vld_r[LW];
  assign out_root = root_r[LW];
  assign out_m    = m_r[LW];
  assign out_side = side_r[LW];
endmodule

FILE: rtl/tfn_div.sv
// tfn_div: pipelined restoring divider for the three normal magnitudes
// depends on tfn_pkg
`timescale 1ns / 1ps
module tfn_div import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [LW-1:0]     in_root,
  input  logic [3*MW-1:0]   in_m,
  input  tfn_side_t         in_side,
  output logic              out_vld,
  output logic [3*QW-1:0]   out_q,
  output tfn_side_t         out_side
);
  // numerator 32768*m + L (< 2^46), divisor 2L, quotient <= 16384 + rounding
  localparam int NUMW = 46;
  localparam int DW   = LW + 1;
  localparam int STEPS = QW + 1;

  logic [STEPS:0]   vld_r;
  logic [NUMW-1:0]  rem_r  [3][STEPS+1];
  logic [STEPS-1:0] q_r    [3][STEPS+1];
  logic [DW-1:0]    den_r  [STEPS+1];
  tfn_side_t        side_r [STEPS+1];

  always_comb begin
    vld_r[0]  = in_vld;
    den_r[0]  = {in_root, 1'b0};
    side_r[0] = in_side;
    for (int i = 0; i < 3; i++) begin
      rem_r[i][0] = ({{(NUMW-MW){1'b0}}, in_m[i*MW +: MW]} << 15)
                  + {{(NUMW-LW){1'b0}}, in_root};
      q_r[i][0]   = '0;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam int B = STEPS - 1 - g;
    logic [NUMW-1:0]    rem_nxt [3];
    logic [STEPS-1:0]   q_nxt   [3];
    logic [NUMW+DW-1:0] dsh;
    // one quotient bit per stage, remainder and quotient kept apart
    always_comb begin
      dsh = {{NUMW{1'b0}}, den_r[g]} << B;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = rem_r[i][g];
        q_nxt[i]   = q_r[i][g];
        if ({{DW{1'b0}}, rem_r[i][g]} >= dsh) begin
          rem_nxt[i] = NUMW'({{DW{1'b0}}, rem_r[i][g]} - dsh);
          q_nxt[i]   = q_r[i][g] | (STEPS'(1) << B);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      for (int i = 0; i < 3; i++) begin
        rem_r[i][g+1] <= rem_nxt[i];
        q_r[i][g+1]   <= q_nxt[i];
      end
      den_r[g+1]  <= den_r[g];
      side_r[g+1] <= side_r[g];
    end
  end

  // clamp the quotient to one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_q[i*QW +: QW] = (q_r[i][STEPS] > STEPS'(NORM_ONE)) ? NORM_ONE
                                                               : QW'(q_r[i][STEPS]);
    end
  end
  assign out_vld  = vld_r[STEPS];
  assign out_side = side_r[STEPS];
endmodule

FILE: rtl/tfn_checker.sv
// tfn_checker: port level checks for triangle_face_normal, bound to the top level
// depends on tfn_pkg
`timescale 1ns / 1ps
module tfn_checker import tfn_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 busy,
  input logic                 out_valid,
  input logic signed [NW-1:0] out_normal_x,
  input logic signed [NW-1:0] out_normal_y,
  input logic signed [NW-1:0] out_normal_z,
  input logic                 out_degenerate
);
  // never refuses a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  // degenerate result carries a zero normal
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == 0 && out_normal_y == 0
      && out_normal_z == 0) else $error("degenerate normal not zero");
  // components stay within unit range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16384 && out_normal_x >= -16384
      && out_normal_y <= 16384 && out_normal_y >= -16384
      && out_normal_z <= 16384 && out_normal_z >= -16384)
    else $error("normal out of range");
  // a good normal is never all zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_normal_x != 0 || out_normal_y != 0
      || out_normal_z != 0) else $error("zero normal without degenerate");
endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (
  .clk, .rst_n, .busy, .out_valid, .out_normal_x, .out_normal_y,
  .out_normal_z, .out_degenerate
);
